// ===== hdl/mme_pkg.sv =====
// Shared types and constants for the 128-bit modular exponentiator.
// No dependencies.
package mme_pkg;

  localparam int CELL_W                = 32;
  localparam int DEFAULT_OPERAND_WIDTH = 128;
  localparam int FIELD_W               = 64;

  // Row control for one cycle.
  typedef struct packed {
    logic clr;   // clear the accumulator
    logic step;  // one interleaved multiply/reduce step
    logic add;   // current multiplier bit
  } mme_ctrl_t;

  // Carry and borrows passed from one cell to the next.
  typedef struct packed {
    logic carry;
    logic b1;    // borrow of s - n
    logic b2;    // borrow of s - 2n
  } mme_link_t;

  // Row-wide choice of the next accumulator value.
  typedef struct packed {
    logic use_d2;
    logic use_d1;
  } mme_sel_t;

endpackage

// ===== hdl/mme_cell.sv =====
// One slice of the modular multiply accumulator.
// Depends on mme_pkg.
module mme_cell import mme_pkg::*; (
  input  logic              clk,
  input  mme_ctrl_t         ctrl,
  input  mme_sel_t          sel,
  input  logic              sh_in,
  input  logic [CELL_W-1:0] y,
  input  logic [CELL_W-1:0] n,
  input  logic [CELL_W-1:0] n2,
  input  mme_link_t         link_in,
  output mme_link_t         link_out,
  output logic              sh_out,
  output logic [CELL_W-1:0] r
);

  logic [CELL_W:0] s_full, d1_full, d2_full;
  logic [CELL_W-1:0] s;

  // s = 2r + add*y, then s - n and s - 2n
  assign s_full  = {1'b0, r[CELL_W-2:0], sh_in} + {1'b0, (ctrl.add ? y : '0)}
                 + (CELL_W+1)'(link_in.carry);
  assign s       = s_full[CELL_W-1:0];
  assign d1_full = {1'b0, s} - {1'b0, n}  - (CELL_W+1)'(link_in.b1);
  assign d2_full = {1'b0, s} - {1'b0, n2} - (CELL_W+1)'(link_in.b2);

  assign link_out.carry = s_full[CELL_W];
  assign link_out.b1    = d1_full[CELL_W];
  assign link_out.b2    = d2_full[CELL_W];
  assign sh_out         = r[CELL_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      r <= '0;
    end else if (ctrl.step) begin
      if (sel.use_d2)      r <= d2_full[CELL_W-1:0];
      else if (sel.use_d1) r <= d1_full[CELL_W-1:0];
      else                 r <= s;
    end
  end

endmodule

// ===== hdl/mme_row.sv =====
// Chain of accumulator cells forming one interleaved modular multiplier.
// Depends on mme_pkg and mme_cell.
module mme_row import mme_pkg::*; #(
  parameter int RW = 160
) (
  input  logic          clk,
  input  mme_ctrl_t     ctrl,
  input  logic [RW-1:0] y,
  input  logic [RW-1:0] n,
  input  logic [RW-1:0] n2,
  output logic [RW-1:0] r
);

  localparam int NC = RW / CELL_W;

  mme_link_t link [NC+1];
  logic      sh   [NC+1];
  mme_sel_t  sel;

  assign link[0] = '0;
  assign sh[0]   = 1'b0;

  // sign of the whole differences comes out of the top cell
  assign sel.use_d2 = !link[NC].b2;
  assign sel.use_d1 = !link[NC].b1;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    mme_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .sel      (sel),
      .sh_in    (sh[i]),
      .y        (y[i*CELL_W +: CELL_W]),
      .n        (n[i*CELL_W +: CELL_W]),
      .n2       (n2[i*CELL_W +: CELL_W]),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .sh_out   (sh[i+1]),
      .r        (r[i*CELL_W +: CELL_W])
    );
  end

endmodule

// ===== hdl/modular_exponentiation_128.sv =====
// Modular exponentiator: base^exponent mod modulus, left-to-right square and multiply.
// Each modular product runs on the cell row as a clear, W steps and a collect, with
// W = OPERAND_WIDTH: one reduction of the base, then W squarings and one multiply per
// set exponent bit. A zero modulus goes straight to done with the error flag set.
// One item at a time: a new item is taken only in idle, after the last result is taken.
// Reset (rst, synchronous) returns to idle and drops any item in flight.
module modular_exponentiation_128 import mme_pkg::*; #(
  parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FIELD_W-1:0] base_low,
  input  logic [FIELD_W-1:0] base_high,
  input  logic [FIELD_W-1:0] exponent_low,
  input  logic [FIELD_W-1:0] exponent_high,
  input  logic [FIELD_W-1:0] modulus_low,
  input  logic [FIELD_W-1:0] modulus_high,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] result_low,
  output logic [FIELD_W-1:0] result_high,
  output logic               zero_modulus_error
);

  localparam int W  = OPERAND_WIDTH;
  // accumulator holds 2r + y < 3n, so two spare bits, rounded up to whole cells
  localparam int RW = ((W + 2 + CELL_W - 1) / CELL_W) * CELL_W;
  localparam int CW = $clog2(W);

  typedef enum logic [2:0] {S_IDLE, S_RED, S_SQ, S_MUL, S_DONE} state_t;
  typedef enum logic [1:0] {Y_ONE, Y_W, Y_B} ysel_t;

  state_t        state;
  ysel_t         ysel;
  logic          first;   // clear cycle of an operation
  logic          last;    // collect cycle of an operation
  logic [CW-1:0] cnt;
  logic [CW-1:0] idx;
  logic [W-1:0]  tt, nn, w, bred, a_sh;
  logic          err;

  logic [2*FIELD_W-1:0] in_b, in_t, in_n, res_wide;
  logic [W-1:0]         b_in, t_in, n_in;
  logic [RW-1:0]        y, n_ext, n2_ext, r;
  mme_ctrl_t            ctrl;

  assign in_b = {base_high, base_low};
  assign in_t = {exponent_high, exponent_low};
  assign in_n = {modulus_high, modulus_low};
  assign b_in = in_b[W-1:0];
  assign t_in = in_t[W-1:0];
  assign n_in = in_n[W-1:0];

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  assign n_ext  = RW'(nn);
  assign n2_ext = RW'(nn) << 1;

  always_comb begin
    unique case (ysel)
      Y_ONE:   y = RW'(1);
      Y_W:     y = RW'(w);
      Y_B:     y = RW'(bred);
      default: y = '0;
    endcase
  end

  // row is stepped while an operation is between its clear and collect cycles
  assign ctrl.clr  = first && (state == S_RED || state == S_SQ || state == S_MUL);
  assign ctrl.step = !first && !last && (state == S_RED || state == S_SQ || state == S_MUL);
  assign ctrl.add  = a_sh[W-1];

  mme_row #(.RW(RW)) u_row (
    .clk  (clk),
    .ctrl (ctrl),
    .y    (y),
    .n    (n_ext),
    .n2   (n2_ext),
    .r    (r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b0;
      last  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tt <= t_in;
            nn <= n_in;
            if (n_in == '0) begin
              err   <= 1'b1;
              w     <= '0;
              state <= S_DONE;
            end else begin
              // 1 mod n, so a zero exponent is already right
              err   <= 1'b0;
              w     <= (n_in == W'(1)) ? '0 : W'(1);
              a_sh  <= b_in;
              ysel  <= Y_ONE;
              first <= 1'b1;
              last  <= 1'b0;
              idx   <= CW'(W - 1);
              state <= S_RED;
            end
          end
        end
        S_RED, S_SQ, S_MUL: begin
          if (first) begin
            first <= 1'b0;
            cnt   <= '0;
          end else if (!last) begin
            a_sh <= a_sh << 1;
            cnt  <= cnt + CW'(1);
            if (cnt == CW'(W - 1)) last <= 1'b1;
          end else begin
            last <= 1'b0;
            if (state == S_RED) begin
              bred  <= r[W-1:0];
              a_sh  <= w;
              ysel  <= Y_W;
              first <= 1'b1;
              state <= S_SQ;
            end else if (state == S_SQ && tt[idx]) begin
              w     <= r[W-1:0];
              a_sh  <= r[W-1:0];
              ysel  <= Y_B;
              first <= 1'b1;
              state <= S_MUL;
            end else begin
              w <= r[W-1:0];
              if (idx == '0) begin
                state <= S_DONE;
              end else begin
                idx   <= idx - CW'(1);
                a_sh  <= r[W-1:0];
                ysel  <= Y_W;
                first <= 1'b1;
                state <= S_SQ;
              end
            end
          end
        end
        S_DONE: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res_wide           = (2*FIELD_W)'(w);
  assign result_low         = res_wide[FIELD_W-1:0];
  assign result_high        = res_wide[2*FIELD_W-1:FIELD_W];
  assign zero_modulus_error = err;

  // zero modulus always answers with zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_modulus_error |-> w == '0)
    else $error("zero modulus item carries a nonzero result");

  // a finished result is fully reduced
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid && !zero_modulus_error |-> w < nn)
    else $error("result not below modulus");

  // row never clears and steps together
  a_ctrl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.clr && ctrl.step))
    else $error("row cleared and stepped in one cycle");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(w))
    else $error("stalled result changed");

endmodule
